@@ hw/rtl/indexed_list_engine_assert.svh @@
// ----------------------------------------------------------------------------
// Indexed list engine assertion macros
// Concurrent assertion wrappers shared by the engine's modules.
// ----------------------------------------------------------------------------
`ifndef INDEXED_LIST_ENGINE_ASSERT_SVH
`define INDEXED_LIST_ENGINE_ASSERT_SVH

`ifndef NO_ASSERTIONS
// Property must hold at every clock edge outside reset.
`define ILE_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("indexed list engine: assertion failed");
// Expression must never be true outside reset.
`define ILE_ASSERT_NEVER(lbl, clk, rst_n, expr) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
    else $error("indexed list engine: forbidden condition seen");
`else
`define ILE_ASSERT(lbl, clk, rst_n, prop)
`define ILE_ASSERT_NEVER(lbl, clk, rst_n, expr)
`endif

`endif

@@ hw/rtl/ile_pkg.sv @@
// ----------------------------------------------------------------------------
// Indexed list engine package
// Sizes, operation and status codes, and controller/datapath interface types.
// ----------------------------------------------------------------------------
package ile_pkg;

  localparam int unsigned CAPACITY   = 16;
  localparam int unsigned DATA_WIDTH = 32;
  localparam int unsigned ADDR_W     = $clog2(CAPACITY);
  localparam int unsigned CNT_W      = $clog2(CAPACITY + 1);
  localparam int unsigned IDX_A_W    = 5;
  localparam int unsigned IDX_B_W    = 4;

  typedef enum logic [2:0] {
    OP_INSERT  = 3'd0,
    OP_REMOVE  = 3'd1,
    OP_READ    = 3'd2,
    OP_WRITE   = 3'd3,
    OP_FIND    = 3'd4,
    OP_COMPARE = 3'd5,
    OP_SWAP    = 3'd6,
    OP_CLEAR   = 3'd7
  } op_e;

  typedef enum logic [1:0] {
    STS_OK    = 2'd0,
    STS_RANGE = 2'd1,
    STS_FULL  = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    ADDR_PTR    = 3'd0,
    ADDR_PTR_M1 = 3'd1,
    ADDR_PTR_P1 = 3'd2,
    ADDR_IA     = 3'd3,
    ADDR_IB     = 3'd4
  } addr_sel_e;

  typedef enum logic [1:0] {
    WD_RDATA = 2'd0,
    WD_VALUE = 2'd1,
    WD_TMP   = 2'd2
  } wdata_sel_e;

  typedef enum logic [2:0] {
    PTR_HOLD = 3'd0,
    PTR_LEN  = 3'd1,
    PTR_IA   = 3'd2,
    PTR_ZERO = 3'd3,
    PTR_INC  = 3'd4,
    PTR_DEC  = 3'd5
  } ptr_op_e;

  typedef enum logic [1:0] {
    LEN_HOLD = 2'd0,
    LEN_INC  = 2'd1,
    LEN_DEC  = 2'd2,
    LEN_CLR  = 2'd3
  } len_op_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_EVAL,
    ST_UP_RD,
    ST_UP_WR,
    ST_INS_WR,
    ST_DN_RD,
    ST_DN_WR,
    ST_RD_WAIT,
    ST_CMP_WAIT,
    ST_FIND_RD,
    ST_FIND_CMP,
    ST_SWAP_RB,
    ST_SWAP_WA,
    ST_SWAP_WB,
    ST_FIN
  } state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic       load;
    logic       rd_en;
    addr_sel_e  rd_sel;
    logic       wr_en;
    addr_sel_e  wr_sel;
    wdata_sel_e wd_sel;
    ptr_op_e    ptr_op;
    len_op_e    len_op;
    logic       tmp_load;
    logic       st_we;
    status_e    st_code;
    logic       rd_capture;
    logic       found_cmp;
    logic       out_load;
  } dp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    op_e  op;
    logic ia_gt_len;
    logic ia_ge_len;
    logic ib_ge_len;
    logic full;
    logic ptr_eq_ia;
    logic ptr_last;
    logic ptr_end;
    logic out_free;
  } dp_sts_t;

endpackage

@@ hw/rtl/ile_dp.sv @@
// ----------------------------------------------------------------------------
// Indexed list engine datapath
// List memory, element count, walk pointer, request and result registers.
// ----------------------------------------------------------------------------
`include "indexed_list_engine_assert.svh"

module ile_dp (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  ile_pkg::op_e                  op_i,
  input  logic [ile_pkg::IDX_A_W-1:0]   index_a_i,
  input  logic [ile_pkg::IDX_B_W-1:0]   index_b_i,
  input  logic signed [31:0]            value_i,
  input  ile_pkg::dp_cmd_t              cmd_i,
  output ile_pkg::dp_sts_t              sts_o,
  input  logic                          out_ready_i,
  output logic                          out_valid_o,
  output logic [1:0]                    status_o,
  output logic signed [31:0]            read_data_o,
  output logic                          found_o,
  output logic [4:0]                    element_count_o
);
  import ile_pkg::*;

  logic [DATA_WIDTH-1:0] mem_q [CAPACITY];
  logic [DATA_WIDTH-1:0] rdata_q;
  logic [DATA_WIDTH-1:0] tmp_q;
  logic [DATA_WIDTH-1:0] wdata;
  logic [ADDR_W-1:0]     raddr;
  logic [ADDR_W-1:0]     waddr;

  op_e                   op_q;
  logic [IDX_A_W-1:0]    ia_q;
  logic [IDX_B_W-1:0]    ib_q;
  logic [DATA_WIDTH-1:0] val_q;

  logic [CNT_W-1:0]      len_q, len_d;
  logic [CNT_W-1:0]      ptr_q, ptr_d;
  logic [CNT_W-1:0]      ptr_m1, ptr_p1;

  status_e               res_st_q;
  logic [DATA_WIDTH-1:0] res_rd_q;
  logic                  res_found_q;

  logic                  out_valid_q;
  status_e               out_st_q;
  logic [DATA_WIDTH-1:0] out_rd_q;
  logic                  out_found_q;
  logic [CNT_W-1:0]      out_cnt_q;

  logic                  full;

  assign ptr_m1 = ptr_q - CNT_W'(1);
  assign ptr_p1 = ptr_q + CNT_W'(1);
  assign full   = (len_q == CNT_W'(CAPACITY));

  function automatic logic [ADDR_W-1:0] sel_addr(
    input addr_sel_e        sel,
    input logic [CNT_W-1:0] ptr,
    input logic [CNT_W-1:0] pm1,
    input logic [CNT_W-1:0] pp1,
    input logic [IDX_A_W-1:0] ia,
    input logic [IDX_B_W-1:0] ib
  );
    logic [ADDR_W-1:0] a;
    case (sel)
      ADDR_PTR:    a = ADDR_W'(ptr);
      ADDR_PTR_M1: a = ADDR_W'(pm1);
      ADDR_PTR_P1: a = ADDR_W'(pp1);
      ADDR_IA:     a = ADDR_W'(ia);
      ADDR_IB:     a = ADDR_W'(ib);
      default:     a = ADDR_W'(ptr);
    endcase
    return a;
  endfunction

  assign raddr = sel_addr(cmd_i.rd_sel, ptr_q, ptr_m1, ptr_p1, ia_q, ib_q);
  assign waddr = sel_addr(cmd_i.wr_sel, ptr_q, ptr_m1, ptr_p1, ia_q, ib_q);

  always_comb begin
    case (cmd_i.wd_sel)
      WD_RDATA: wdata = rdata_q;
      WD_VALUE: wdata = val_q;
      WD_TMP:   wdata = tmp_q;
      default:  wdata = rdata_q;
    endcase
  end

  // List memory: one write port, one registered read port.
  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_en) begin
      mem_q[waddr] <= wdata;
    end
    if (cmd_i.rd_en) begin
      rdata_q <= mem_q[raddr];
    end
  end

  always_comb begin
    case (cmd_i.ptr_op)
      PTR_LEN:  ptr_d = len_q;
      PTR_IA:   ptr_d = ia_q;
      PTR_ZERO: ptr_d = '0;
      PTR_INC:  ptr_d = ptr_p1;
      PTR_DEC:  ptr_d = ptr_m1;
      default:  ptr_d = ptr_q;
    endcase
  end

  always_comb begin
    case (cmd_i.len_op)
      LEN_INC: len_d = len_q + CNT_W'(1);
      LEN_DEC: len_d = len_q - CNT_W'(1);
      LEN_CLR: len_d = '0;
      default: len_d = len_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      len_q <= len_d;
      if (cmd_i.out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Request, walk and result registers carry payload only.
  always_ff @(posedge clk_i) begin
    ptr_q <= ptr_d;
    if (cmd_i.load) begin
      op_q        <= op_i;
      ia_q        <= index_a_i;
      ib_q        <= index_b_i;
      val_q       <= value_i;
      res_st_q    <= STS_OK;
      res_rd_q    <= '0;
      res_found_q <= 1'b0;
    end else begin
      if (cmd_i.st_we) begin
        res_st_q <= cmd_i.st_code;
      end
      if (cmd_i.rd_capture) begin
        res_rd_q <= rdata_q;
      end
      if (cmd_i.found_cmp && (rdata_q == val_q)) begin
        res_found_q <= 1'b1;
      end
    end
    if (cmd_i.tmp_load) begin
      tmp_q <= rdata_q;
    end
    if (cmd_i.out_load) begin
      out_st_q    <= res_st_q;
      out_rd_q    <= res_rd_q;
      out_found_q <= res_found_q;
      out_cnt_q   <= len_q;
    end
  end

  always_comb begin
    sts_o.op        = op_q;
    sts_o.ia_gt_len = (ia_q > len_q);
    sts_o.ia_ge_len = (ia_q >= len_q);
    sts_o.ib_ge_len = (CNT_W'(ib_q) >= len_q);
    sts_o.full      = full;
    sts_o.ptr_eq_ia = (ptr_q == ia_q);
    sts_o.ptr_last  = (ptr_p1 >= len_q);
    sts_o.ptr_end   = (ptr_q >= len_q);
    sts_o.out_free  = !out_valid_q || out_ready_i;
  end

  assign out_valid_o     = out_valid_q;
  assign status_o        = out_st_q;
  assign read_data_o     = out_rd_q;
  assign found_o         = out_found_q;
  assign element_count_o = out_cnt_q;

  `ILE_ASSERT_NEVER(a_len_bound, clk_i, rst_ni, len_q > CNT_W'(CAPACITY))
  `ILE_ASSERT(a_inc_not_full, clk_i, rst_ni, (cmd_i.len_op == LEN_INC) |-> !full)
  `ILE_ASSERT(a_out_load_valid, clk_i, rst_ni, cmd_i.out_load |=> out_valid_q)

endmodule

@@ hw/rtl/ile_ctrl.sv @@
// ----------------------------------------------------------------------------
// Indexed list engine controller
// Sequences each request over the datapath's list memory, one access per state.
// ----------------------------------------------------------------------------
`include "indexed_list_engine_assert.svh"

module ile_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  ile_pkg::dp_sts_t  sts_i,
  output ile_pkg::dp_cmd_t  cmd_o
);
  import ile_pkg::*;

  state_e state_q, state_d;
  logic   accept;

  assign in_ready_o = (state_q == ST_IDLE);
  assign accept     = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (accept) state_d = ST_EVAL;
      end
      ST_EVAL: begin
        case (sts_i.op)
          OP_INSERT:  state_d = (sts_i.ia_gt_len || sts_i.full) ? ST_FIN : ST_UP_RD;
          OP_REMOVE:  state_d = sts_i.ia_ge_len ? ST_FIN : ST_DN_RD;
          OP_READ:    state_d = sts_i.ia_ge_len ? ST_FIN : ST_RD_WAIT;
          OP_WRITE:   state_d = ST_FIN;
          OP_FIND:    state_d = ST_FIND_RD;
          OP_COMPARE: state_d = sts_i.ia_ge_len ? ST_FIN : ST_CMP_WAIT;
          OP_SWAP: begin
            state_d = (sts_i.ia_ge_len || sts_i.ib_ge_len) ? ST_FIN : ST_SWAP_RB;
          end
          default:    state_d = ST_FIN;
        endcase
      end
      ST_UP_RD:    state_d = sts_i.ptr_eq_ia ? ST_INS_WR : ST_UP_WR;
      ST_UP_WR:    state_d = ST_UP_RD;
      ST_INS_WR:   state_d = ST_FIN;
      ST_DN_RD:    state_d = sts_i.ptr_last ? ST_FIN : ST_DN_WR;
      ST_DN_WR:    state_d = ST_DN_RD;
      ST_RD_WAIT:  state_d = ST_FIN;
      ST_CMP_WAIT: state_d = ST_FIN;
      ST_FIND_RD:  state_d = sts_i.ptr_end ? ST_FIN : ST_FIND_CMP;
      ST_FIND_CMP: state_d = ST_FIND_RD;
      ST_SWAP_RB:  state_d = ST_SWAP_WA;
      ST_SWAP_WA:  state_d = ST_SWAP_WB;
      ST_SWAP_WB:  state_d = ST_FIN;
      ST_FIN: begin
        if (sts_i.out_free) state_d = ST_IDLE;
      end
      default:     state_d = ST_IDLE;
    endcase
  end

  // Datapath commands.
  always_comb begin
    cmd_o      = '0;
    cmd_o.load = accept;
    case (state_q)
      ST_EVAL: begin
        case (sts_i.op)
          OP_INSERT: begin
            cmd_o.st_we   = sts_i.ia_gt_len || sts_i.full;
            cmd_o.st_code = sts_i.ia_gt_len ? STS_RANGE : STS_FULL;
            cmd_o.ptr_op  = PTR_LEN;
          end
          OP_REMOVE: begin
            cmd_o.st_we   = sts_i.ia_ge_len;
            cmd_o.st_code = STS_RANGE;
            cmd_o.ptr_op  = PTR_IA;
          end
          OP_READ, OP_COMPARE: begin
            cmd_o.st_we   = sts_i.ia_ge_len;
            cmd_o.st_code = STS_RANGE;
            cmd_o.rd_en   = !sts_i.ia_ge_len;
            cmd_o.rd_sel  = ADDR_IA;
          end
          OP_WRITE: begin
            cmd_o.st_we   = sts_i.ia_ge_len;
            cmd_o.st_code = STS_RANGE;
            cmd_o.wr_en   = !sts_i.ia_ge_len;
            cmd_o.wr_sel  = ADDR_IA;
            cmd_o.wd_sel  = WD_VALUE;
          end
          OP_FIND: begin
            cmd_o.ptr_op = PTR_ZERO;
          end
          OP_SWAP: begin
            cmd_o.st_we   = sts_i.ia_ge_len || sts_i.ib_ge_len;
            cmd_o.st_code = STS_RANGE;
            cmd_o.rd_en   = 1'b1;
            cmd_o.rd_sel  = ADDR_IA;
          end
          default: begin
            cmd_o.len_op = LEN_CLR;
          end
        endcase
      end
      ST_UP_RD: begin
        cmd_o.rd_en  = !sts_i.ptr_eq_ia;
        cmd_o.rd_sel = ADDR_PTR_M1;
      end
      ST_UP_WR: begin
        cmd_o.wr_en  = 1'b1;
        cmd_o.wr_sel = ADDR_PTR;
        cmd_o.wd_sel = WD_RDATA;
        cmd_o.ptr_op = PTR_DEC;
      end
      ST_INS_WR: begin
        cmd_o.wr_en  = 1'b1;
        cmd_o.wr_sel = ADDR_IA;
        cmd_o.wd_sel = WD_VALUE;
        cmd_o.len_op = LEN_INC;
      end
      ST_DN_RD: begin
        cmd_o.rd_en  = !sts_i.ptr_last;
        cmd_o.rd_sel = ADDR_PTR_P1;
        cmd_o.len_op = sts_i.ptr_last ? LEN_DEC : LEN_HOLD;
      end
      ST_DN_WR: begin
        cmd_o.wr_en  = 1'b1;
        cmd_o.wr_sel = ADDR_PTR;
        cmd_o.wd_sel = WD_RDATA;
        cmd_o.ptr_op = PTR_INC;
      end
      ST_RD_WAIT: begin
        cmd_o.rd_capture = 1'b1;
      end
      ST_CMP_WAIT, ST_FIND_CMP: begin
        cmd_o.found_cmp = 1'b1;
      end
      ST_FIND_RD: begin
        cmd_o.rd_en  = !sts_i.ptr_end;
        cmd_o.rd_sel = ADDR_PTR;
        cmd_o.ptr_op = sts_i.ptr_end ? PTR_HOLD : PTR_INC;
      end
      ST_SWAP_RB: begin
        cmd_o.rd_en    = 1'b1;
        cmd_o.rd_sel   = ADDR_IB;
        cmd_o.tmp_load = 1'b1;
      end
      ST_SWAP_WA: begin
        cmd_o.wr_en  = 1'b1;
        cmd_o.wr_sel = ADDR_IA;
        cmd_o.wd_sel = WD_RDATA;
      end
      ST_SWAP_WB: begin
        cmd_o.wr_en  = 1'b1;
        cmd_o.wr_sel = ADDR_IB;
        cmd_o.wd_sel = WD_TMP;
      end
      ST_FIN: begin
        cmd_o.out_load = sts_i.out_free;
      end
      default: begin
        cmd_o.rd_en = 1'b0;
      end
    endcase
  end

  `ILE_ASSERT(a_wr_busy, clk_i, rst_ni, cmd_o.wr_en |-> (state_q != ST_IDLE))
  `ILE_ASSERT(a_load_free, clk_i, rst_ni, cmd_o.out_load |-> sts_i.out_free)
  `ILE_ASSERT(a_accept_eval, clk_i, rst_ni, accept |=> (state_q == ST_EVAL))

endmodule

@@ hw/rtl/indexed_list_engine.sv @@
// Sequencing: each request passes the evaluate and finish states; insert and
// remove shift every element between the position and the end of the list, a
// read and a write each, and find reads and compares every element in turn.
// Throughput: one request at a time; the next is taken once the previous
// one's result sits in the output register, which may still be waiting.
// Reset: asynchronous, active low; the list comes up empty, no clearing pass.
// ----------------------------------------------------------------------------
// Indexed list engine
// Ordered list of signed words addressed by position, with insert, remove,
// read, write, find, compare, swap and clear requests over stream channels.
// ----------------------------------------------------------------------------
module indexed_list_engine (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Request channel.
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [47:0] s_axis_tdata,  // index_a[4:0], index_b[8:5], value[40:9]
  input  logic [2:0]  s_axis_tuser,  // op[2:0]
  // Result channel.
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata   // status[1:0], read_data[33:2], found[34],
                                     // element_count[39:35]
);
  import ile_pkg::*;

  // The controller walks each request through the datapath; the two talk only
  // through the command and status structs below.
  dp_cmd_t            cmd;
  dp_sts_t            sts;

  logic [1:0]         res_status;
  logic signed [31:0] res_read_data;
  logic               res_found;
  logic [4:0]         res_count;

  ile_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // The datapath owns the list memory, the element count and the output
  // register, so a finished result can wait while the next request enters.
  ile_dp u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .op_i            (op_e'(s_axis_tuser[2:0])),
    .index_a_i       (s_axis_tdata[4:0]),
    .index_b_i       (s_axis_tdata[8:5]),
    .value_i         (s_axis_tdata[40:9]),
    .cmd_i           (cmd),
    .sts_o           (sts),
    .out_ready_i     (m_axis_tready),
    .out_valid_o     (m_axis_tvalid),
    .status_o        (res_status),
    .read_data_o     (res_read_data),
    .found_o         (res_found),
    .element_count_o (res_count)
  );

  // Result fields packed from the lowest bit up; exactly five bytes.
  assign m_axis_tdata = {res_count, res_found, res_read_data, res_status};

endmodule
